// ----- rtl/ifmt_pkg.sv -----
// ============================================================================
// ifmt_pkg - shared types and constants of the integer field formatter
// Digit store geometry, conversion codes, ASCII codes and the command word
// that the sequencer sends to the digit engine.
// ============================================================================
`default_nettype none

package ifmt_pkg;

	// Conversion kinds as carried in the low bits of the input tuser.
	localparam logic [1:0] KIND_SDEC = 2'd0;
	localparam logic [1:0] KIND_UDEC = 2'd1;
	localparam logic [1:0] KIND_HEX  = 2'd2;
	localparam logic [1:0] KIND_OCT  = 2'd3;

	// Width of the integer operand and number of digit slots in the store.
	localparam int VAL_W  = 64;
	localparam int NDIG   = 24;
	localparam int NDIG_W = $clog2(NDIG + 1);
	localparam int STEP_W = $clog2(VAL_W);

	// Packed word widths on the stream ports.
	localparam int IN_DATA_W = 80;
	localparam int IN_USER_W = 3;
	localparam int OUT_DATA_W = 8;

	// ASCII codes used by the formatter.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_UC_A  = 8'h41;

	typedef logic [3:0] digit_t;

	// One command per cycle to the digit engine; load wins over the others.
	typedef struct packed {
		logic load;
		logic dabble;
		logic shift;
	} ifmt_cmd_t;

	// ASCII text of one digit; letters only appear for hexadecimal.
	function automatic logic [7:0] digit_char(input digit_t d, input logic up);
		logic [7:0] base;
		begin
			if (d < 4'd10) begin
				digit_char = CH_ZERO + {4'b0000, d};
			end else begin
				base = up ? CH_UC_A : CH_LC_A;
				digit_char = base + {4'b0000, d} - 8'd10;
			end
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ifmt_digits.sv -----
// ============================================================================
// ifmt_digits - digit engine of the integer field formatter
// Holds the digit store, converts binary to BCD one bit per cycle by
// shift-and-add-3, and shifts digits toward the top slot for output.
// ============================================================================
`default_nettype none

module ifmt_digits
	import ifmt_pkg::*;
(
	input  wire logic             clk,
	input  wire ifmt_cmd_t        cmd,
	input  wire logic [1:0]       kind,
	input  wire logic [VAL_W-1:0] mag,
	output      digit_t           top_digit
);

	digit_t             dig_q [NDIG];
	digit_t             adj   [NDIG];
	logic [VAL_W-1:0]   bin_q;
	logic [4*NDIG-1:0]  hex_src;
	logic [3*NDIG-1:0]  oct_src;

	assign hex_src = (4*NDIG)'(mag);
	assign oct_src = (3*NDIG)'(mag);
	assign top_digit = dig_q[NDIG-1];

	// Digits of five or more get three added before the shift doubles them.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag;
			for (int i = 0; i < NDIG; i++) begin
				case (kind)
					KIND_HEX: dig_q[i] <= hex_src[4*i +: 4];
					KIND_OCT: dig_q[i] <= {1'b0, oct_src[3*i +: 3]};
					default:  dig_q[i] <= '0;
				endcase
			end
		end else if (cmd.dabble) begin
			bin_q <= {bin_q[VAL_W-2:0], 1'b0};
			dig_q[0] <= {adj[0][2:0], bin_q[VAL_W-1]};
			for (int i = 1; i < NDIG; i++) begin
				dig_q[i] <= {adj[i][2:0], adj[i-1][3]};
			end
		end else if (cmd.shift) begin
			dig_q[0] <= '0;
			for (int i = 1; i < NDIG; i++) begin
				dig_q[i] <= dig_q[i-1];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/integer_field_formatter.sv -----
// ============================================================================
// integer_field_formatter - printf-style integer to ASCII field formatter
// Turns one integer and its conversion options into a padded text field,
// one character per output word.
// ============================================================================
//
// Each input word carries a 32- or 64-bit integer and its conversion settings;
// the block answers with the ASCII text of that integer, one character per
// output word, with tlast on the final character. Conversions are signed
// decimal, unsigned decimal, hexadecimal and octal, with optional plus sign,
// 0x/0X or 0 prefix, upper-case hex and a minimum field width. Right-aligned
// fill (space or zero) goes in front of the whole text, even before a sign;
// left-aligned fill is always spaces. Widths above MAX_FIELD are clamped.
// Timing: an input word is taken only when the block is idle. Decimal values
// go through a bit-serial binary to BCD converter, after which leading zero
// digits are shifted out one per cycle over a 24-slot digit store. Output
// characters leave through the output register at one per cycle while the
// receiver does not stall. The last character may still wait in the output
// register while the next input word is taken.
//
`default_nettype none

module integer_field_formatter
	import ifmt_pkg::*;
#(
	parameter int MAX_FIELD = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input stream.
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	// tdata from bit 0: value[63:0], upper_case, plus_sign, alt_prefix,
	// left_align, zero_fill, field_width[6:0], zero fill to 80 bits.
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// tuser from bit 0: kind[1:0], wide.
	input  wire logic [IN_USER_W-1:0]  s_tuser,
	// Output stream.
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	// tdata from bit 0: char_out[7:0].
	output      logic [OUT_DATA_W-1:0] m_tdata,
	output      logic                  m_tlast
);

	// Character counters must hold both the widest field and the longest text
	// (sign or prefix plus a full digit store).
	localparam int TXT_MAX = NDIG + 2;
	localparam int CNT_MAX = (MAX_FIELD > TXT_MAX) ? MAX_FIELD : TXT_MAX;
	localparam int CW      = $clog2(CNT_MAX + 1);
	localparam logic [6:0] MAXF_7 = 7'(MAX_FIELD);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CONV  = 3'd1;
	localparam logic [2:0] S_NORM  = 3'd2;
	localparam logic [2:0] S_SETUP = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0]        state_q;
	logic              ov_q;
	logic [7:0]        och_q;
	logic              olast_q;

	// Per-word settings captured on input.
	logic [1:0]        kind_q;
	logic              neg_q;
	logic              up_q;
	logic              plus_q;
	logic              alt_q;
	logic              left_q;
	logic              zfill_q;
	logic [CW-1:0]     w_q;

	// Working counters.
	logic [STEP_W-1:0] step_q;
	logic [NDIG_W-1:0] ndig_q;
	logic [1:0]        plen_q;
	logic [7:0]        pfx0_q;
	logic [7:0]        pfx1_q;
	logic [CW-1:0]     lp_q;
	logic [CW-1:0]     rp_q;
	logic [CW-1:0]     rem_q;

	// Input word fields.
	logic [1:0]        in_kind;
	logic              in_wide;
	logic [VAL_W-1:0]  in_u;
	logic [VAL_W-1:0]  in_mask;
	logic              in_neg;
	logic [VAL_W-1:0]  in_mag;
	logic [6:0]        in_fw;
	logic              accept;

	ifmt_cmd_t         cmd;
	digit_t            top_digit;
	logic              top_zero;
	logic              norm_more;
	logic              emit_go;
	logic [7:0]        emit_char;
	logic              emit_digit;

	// Text setup terms.
	logic [1:0]        su_plen;
	logic [7:0]        su_pfx0;
	logic [7:0]        su_pfx1;
	logic [CW-1:0]     su_len;
	logic [CW-1:0]     su_total;
	logic [CW-1:0]     su_pad;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign in_kind = s_tuser[1:0];
	assign in_wide = s_tuser[2];
	assign in_fw   = s_tdata[75:69];
	assign in_mask = in_wide ? {VAL_W{1'b1}} : {{(VAL_W/2){1'b0}}, {(VAL_W/2){1'b1}}};
	assign in_u    = s_tdata[VAL_W-1:0] & in_mask;
	assign in_neg  = (in_kind == KIND_SDEC) &&
		(in_wide ? s_tdata[VAL_W-1] : s_tdata[VAL_W/2-1]);
	// The most negative value negates to itself, which read unsigned is its
	// true magnitude.
	assign in_mag  = in_neg ? ((~in_u + 64'd1) & in_mask) : in_u;

	assign top_zero  = (top_digit == 4'd0);
	assign norm_more = (ndig_q > NDIG_W'(1)) && top_zero;
	assign emit_go   = (state_q == S_EMIT) && (!ov_q || m_tready);
	assign emit_digit = (lp_q == '0) && (plen_q == 2'd0) && (ndig_q != '0);

	assign cmd.load   = accept;
	assign cmd.dabble = (state_q == S_CONV);
	assign cmd.shift  = ((state_q == S_NORM) && norm_more) || (emit_go && emit_digit);

	ifmt_digits u_digits (
		.clk       (clk),
		.cmd       (cmd),
		.kind      (in_kind),
		.mag       (in_mag),
		.top_digit (top_digit)
	);

	// Sign or prefix text. After normalizing, a zero value is one zero digit.
	always_comb begin
		su_plen = 2'd0;
		su_pfx0 = CH_ZERO;
		su_pfx1 = CH_ZERO;
		case (kind_q)
			KIND_SDEC: begin
				if (neg_q) begin
					su_plen = 2'd1;
					su_pfx0 = CH_MINUS;
				end else if (plus_q && !top_zero) begin
					su_plen = 2'd1;
					su_pfx0 = CH_PLUS;
				end
			end
			KIND_UDEC: begin
				if (plus_q) begin
					su_plen = 2'd1;
					su_pfx0 = CH_PLUS;
				end
			end
			KIND_HEX: begin
				if (alt_q) begin
					su_plen = 2'd2;
					su_pfx1 = up_q ? CH_UC_X : CH_LC_X;
				end
			end
			KIND_OCT: begin
				// A zero value already prints as a single zero.
				if (alt_q && !top_zero) begin
					su_plen = 2'd1;
				end
			end
			default: begin
				su_plen = 2'd0;
			end
		endcase
		su_len   = CW'(su_plen) + CW'(ndig_q);
		su_total = (w_q > su_len) ? w_q : su_len;
		su_pad   = su_total - su_len;
	end

	// Character order: left fill, sign or prefix, digits, right fill.
	always_comb begin
		if (lp_q != '0) begin
			emit_char = zfill_q ? CH_ZERO : CH_SPACE;
		end else if (plen_q != 2'd0) begin
			emit_char = pfx0_q;
		end else if (ndig_q != '0) begin
			emit_char = digit_char(top_digit, up_q);
		end else begin
			emit_char = CH_SPACE;
		end
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (in_kind == KIND_SDEC || in_kind == KIND_UDEC) ?
							S_CONV : S_NORM;
					end
				end
				S_CONV: begin
					if (step_q == {STEP_W{1'b1}}) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (!norm_more) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go && rem_q == CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (emit_go) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Word settings, counters and the output character.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= in_kind;
			neg_q   <= in_neg;
			up_q    <= s_tdata[64];
			plus_q  <= s_tdata[65];
			alt_q   <= s_tdata[66];
			left_q  <= s_tdata[67];
			zfill_q <= s_tdata[68];
			w_q     <= (in_fw > MAXF_7) ? CW'(MAXF_7) : CW'(in_fw);
			step_q  <= '0;
			ndig_q  <= NDIG_W'(NDIG);
		end

		if (state_q == S_CONV) begin
			step_q <= step_q + STEP_W'(1);
		end

		if (state_q == S_NORM && norm_more) begin
			ndig_q <= ndig_q - NDIG_W'(1);
		end

		if (state_q == S_SETUP) begin
			plen_q <= su_plen;
			pfx0_q <= su_pfx0;
			pfx1_q <= su_pfx1;
			lp_q   <= left_q ? '0 : su_pad;
			rp_q   <= left_q ? su_pad : '0;
			rem_q  <= su_total;
		end

		if (emit_go) begin
			och_q   <= emit_char;
			olast_q <= (rem_q == CW'(1));
			rem_q   <= rem_q - CW'(1);
			if (lp_q != '0) begin
				lp_q <= lp_q - CW'(1);
			end else if (plen_q != 2'd0) begin
				plen_q <= plen_q - 2'd1;
				pfx0_q <= pfx1_q;
			end else if (ndig_q != '0) begin
				ndig_q <= ndig_q - NDIG_W'(1);
			end else if (rp_q != '0) begin
				rp_q <= rp_q - CW'(1);
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = och_q;
	assign m_tlast  = olast_q;

endmodule

`default_nettype wire

// ----- dv/ifmt_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ifmt_checker - output checker of the integer field formatter
// Watches both stream channels, formats each accepted input word into the
// characters it must produce, and compares every output word against them.
// ============================================================================

module ifmt_checker
	import ifmt_pkg::*;
#(
	parameter int MAX_FIELD = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	// tdata from bit 0: value[63:0], upper_case, plus_sign, alt_prefix,
	// left_align, zero_fill, field_width[6:0], zero fill to 80 bits.
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// tuser from bit 0: kind[1:0], wide.
	input  wire logic [IN_USER_W-1:0]  s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	// tdata from bit 0: char_out[7:0].
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  m_tlast,
	output int                         fail_count,
	output int                         pending
);

	typedef struct packed {
		logic [7:0] char_out;
		logic       last_char;
	} field_char_t;

	// Characters still owed by the block, oldest first.
	field_char_t expected_chars[$];
	// Unpadded text of the field being formatted.
	logic [7:0]  field_text[$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// Appends the digits of mag in radix 8, 10 or 16, most significant first.
	function automatic void add_digits(input logic [63:0] mag, input logic [63:0] radix,
		input logic up);
		logic [7:0]  rev[0:23];
		logic [63:0] rest;
		logic [63:0] rem;
		logic [3:0]  d;
		int          k;
		int          i;
		rest = mag;
		k = 0;
		if (rest == 64'd0) begin
			rev[0] = CH_ZERO;
			k = 1;
		end
		while (rest != 64'd0) begin
			rem = rest % radix;
			d = rem[3:0];
			if (d < 4'd10) begin
				rev[k] = CH_ZERO + {4'b0000, d};
			end else begin
				rev[k] = (up ? CH_UC_A : CH_LC_A) + {4'b0000, d} - 8'd10;
			end
			k++;
			rest = rest / radix;
		end
		for (i = k - 1; i >= 0; i--) begin
			field_text.push_back(rev[i]);
		end
	endfunction

	// Builds the padded field of one input word and queues its characters.
	function automatic void format_field(input logic [1:0] kind, input logic [63:0] value,
		input logic wide, input logic up, input logic plus, input logic prefix,
		input logic left, input logic zfill, input logic [6:0] width);
		logic [63:0] u;
		logic [63:0] mag;
		logic        neg;
		int          n;
		int          w;
		int          total;
		int          pad;
		int          i;
		field_char_t c;
		field_text.delete();
		u = wide ? value : {32'd0, value[31:0]};
		case (kind)
			KIND_SDEC: begin
				if (wide) begin
					neg = u[63];
					mag = neg ? -u : u;
				end else begin
					neg = u[31];
					mag = neg ? ((-u) & 64'h0000_0000_FFFF_FFFF) : u;
				end
				if (neg) begin
					field_text.push_back(CH_MINUS);
				end else if (plus && mag != 64'd0) begin
					field_text.push_back(CH_PLUS);
				end
				add_digits(mag, 64'd10, 1'b0);
			end
			KIND_UDEC: begin
				if (plus) begin
					field_text.push_back(CH_PLUS);
				end
				add_digits(u, 64'd10, 1'b0);
			end
			KIND_HEX: begin
				if (prefix) begin
					field_text.push_back(CH_ZERO);
					field_text.push_back(up ? CH_UC_X : CH_LC_X);
				end
				add_digits(u, 64'd16, up);
			end
			default: begin
				// A zero in octal is a lone 0, whether or not the prefix asks for one.
				if (prefix) begin
					field_text.push_back(CH_ZERO);
					if (u != 64'd0) begin
						add_digits(u, 64'd8, 1'b0);
					end
				end else begin
					add_digits(u, 64'd8, 1'b0);
				end
			end
		endcase
		n = field_text.size();
		w = (int'(width) > MAX_FIELD) ? MAX_FIELD : int'(width);
		total = (w > n) ? w : n;
		pad = total - n;
		for (i = 0; i < total; i++) begin
			if (left) begin
				c.char_out = (i < n) ? field_text[i] : CH_SPACE;
			end else begin
				c.char_out = (i < pad) ? (zfill ? CH_ZERO : CH_SPACE) : field_text[i - pad];
			end
			c.last_char = (i == total - 1);
			expected_chars.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		field_char_t want;
		if (arst_n) begin
			// Output first, so a word can never be matched against the input
			// accepted at the same edge.
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected output word: char_out %h, last_char %b", m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata !== want.char_out) begin
						$error("char_out mismatch: expected %h, actual %h",
							want.char_out, m_tdata);
						fail_count++;
					end
					if (m_tlast !== want.last_char) begin
						$error("last_char mismatch: expected %b, actual %b",
							want.last_char, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				format_field(s_tuser[1:0], s_tdata[63:0], s_tuser[2], s_tdata[64], s_tdata[65],
					s_tdata[66], s_tdata[67], s_tdata[68], s_tdata[75:69]);
			end
			pending = expected_chars.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb - testbench of the integer field formatter
// Sends directed and random integers with their conversion options through
// the input stream under changing idle and stall patterns; a separate checker
// predicts every output character and flags any difference.
// ============================================================================

module tb;
	import ifmt_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// tdata from bit 0: value[63:0], upper_case, plus_sign, alt_prefix,
	// left_align, zero_fill, field_width[6:0], zero fill to 80 bits.
	logic [IN_DATA_W-1:0]  s_tdata;
	// tuser from bit 0: kind[1:0], wide.
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// tdata from bit 0: char_out[7:0].
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	int fail_count;
	int pending;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int tx_idle_pct;
	int rx_stall_pct;

	integer_field_formatter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	ifmt_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// The receiver decides at every falling edge whether it takes the next word.
	always @(negedge clk) begin
		m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
	end

	// Hands one integer with its options to the block. The task is entered just
	// after a falling edge and returns just after the falling edge that follows
	// the handshake, so every input changes only on falling edges. While the
	// sender idles, tdata carries junk to show that it is ignored.
	task automatic send_value(input logic [1:0] kind, input logic [63:0] value,
		input logic wide, input logic up, input logic plus, input logic prefix,
		input logic left, input logic zfill, input logic [6:0] width);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= IN_DATA_W'({$urandom, $urandom, $urandom});
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, width, zfill, left, prefix, plus, up, value};
		s_tuser  <= {wide, kind};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Mostly values that sit on the interesting edges: tiny numbers, the
	// signed limits at both widths, and magnitudes of every digit count.
	// In most cases bits above 31 are random, so that narrow words show they are unused.
	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(6))
			0: v = {$urandom, 32'd0 + $urandom_range(20)};
			1: v = 64'd0 + $urandom_range(20);
			2: begin
				case ($urandom_range(3))
					0: v = 64'h8000_0000_0000_0000;
					1: v = 64'h7FFF_FFFF_FFFF_FFFF;
					2: v = 64'hFFFF_FFFF_FFFF_FFFF;
					default: v = 64'h0000_0000_0000_0000;
				endcase
			end
			3: begin
				case ($urandom_range(2))
					0: v = {$urandom, 32'h8000_0000};
					1: v = {$urandom, 32'h7FFF_FFFF};
					default: v = {$urandom, 32'hFFFF_FFFF};
				endcase
			end
			4: v = v >> $urandom_range(63);
			default: ;
		endcase
		return v;
	endfunction

	// Random words: all kinds and option bits evenly, widths mostly short,
	// with an occasional one across the whole 7-bit range to reach the clamp.
	task automatic send_random(input int count);
		logic [6:0] width;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(7) == 0) begin
				width = 7'($urandom_range(127));
			end else begin
				width = 7'($urandom_range(24));
			end
			send_value(2'($urandom_range(3)), pick_value(), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)), width);
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		m_tready     = 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words, sent back to back with a receiver that never stalls.
		// Arguments: kind, value, wide, upper_case, plus_sign, alt_prefix,
		// left_align, zero_fill, field_width.
		send_value(KIND_SDEC, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		// Most negative values keep their full magnitude.
		send_value(KIND_SDEC, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		send_value(KIND_SDEC, 64'hDEAD_BEEF_8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		send_value(KIND_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
		// Zero fill goes in front of the sign.
		send_value(KIND_SDEC, 64'd5, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 7'd8);
		send_value(KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd6);
		// A zero gets no plus sign in signed decimal.
		send_value(KIND_SDEC, 64'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
		send_value(KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
		// Left alignment pads with spaces even when zero fill is set.
		send_value(KIND_UDEC, 64'h1234_5678_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 7'd12);
		send_value(KIND_UDEC, 64'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
		send_value(KIND_HEX, 64'hDEAD_BEEF_CAFE_F00D, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
		send_value(KIND_HEX, 64'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
		// Plus sign has no effect on hex; upper bits are ignored when narrow.
		send_value(KIND_HEX, 64'h5555_AAAA_ABCD_EF12, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 7'd20);
		send_value(KIND_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 7'd64);
		// Octal zero is a single 0 with or without the prefix.
		send_value(KIND_OCT, 64'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
		send_value(KIND_OCT, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		send_value(KIND_OCT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
		// Widths above the maximum field are clamped.
		send_value(KIND_OCT, 64'd8, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 7'd127);
		send_value(KIND_SDEC, 64'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd64);
		send_value(KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd65);
		// A width below the text length does not cut the text.
		send_value(KIND_HEX, 64'h1234_5678, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 7'd3);
		send_value(KIND_SDEC, 64'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 7'd64);

		// Random words in four pressure phases: none, idle sender, stalling
		// receiver, and both at once.
		send_random(40);
		tx_idle_pct = 47;
		send_random(40);
		tx_idle_pct  = 0;
		rx_stall_pct = 47;
		send_random(40);
		tx_idle_pct  = 21;
		rx_stall_pct = 21;
		send_random(40);

		s_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		// Give a stray extra word time to show up.
		repeat (200) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Safety net far beyond the slowest correct run.
	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- integer_field_formatter.f -----
rtl/ifmt_pkg.sv
rtl/ifmt_digits.sv
rtl/integer_field_formatter.sv
dv/ifmt_checker.sv
dv/tb.sv
